// ----- sv/q931_pkg.sv -----
// shared types, constants and helper functions of the q.931 message parser
package q931_pkg;

    localparam int MAX_MSG_BYTES = 1024;
    localparam int OFF_W         = $clog2(MAX_MSG_BYTES) + 1;
    localparam int FIELD_W       = 10;
    localparam int EXTRA_SLOTS   = 8;
    localparam int SLOT_W        = (EXTRA_SLOTS > 1) ? $clog2(EXTRA_SLOTS) : 1;
    localparam int IE_POSITIONS  = 34;
    localparam int POS_W         = 6;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    // octet codes
    localparam logic [3:0]  SHIFT_HI      = 4'h9;
    localparam logic [3:0]  CONGESTION_HI = 4'hB;
    localparam logic [7:0]  OCT_MORE      = 8'hA0;
    localparam logic [7:0]  OCT_COMPLETE  = 8'hA1;
    localparam logic [7:0]  COMP_LIMIT    = 8'h10;
    localparam logic [7:0]  MAX_REF_LEN   = 8'd2;
    localparam logic [15:0] REF_FLAG      = 16'h8000;
    localparam logic [15:0] REF_FLAG_MASK = 16'h807F;

    typedef enum logic [2:0] {
        PH_PD, PH_CRLEN, PH_CREF, PH_TYPE, PH_IE, PH_IELEN, PH_BODY, PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_VAR, KIND_REGION, KIND_SUMMARY, KIND_SINGLE
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK, STAT_UNKNOWN_IE, STAT_UNKNOWN_COMP, STAT_BAD_REF_LEN,
        STAT_LENGTH, STAT_SLOT_OVERFLOW
    } status_t;

    typedef enum logic [1:0] {
        CRK_DUMMY, CRK_GLOBAL, CRK_ORDINARY
    } crk_t;

    typedef struct packed {
        kind_t               kind;
        logic [7:0]          ie_code;
        logic [POS_W-1:0]    index;
        logic                repeated;
        logic [FIELD_W-1:0]  offset;
        logic [FIELD_W-1:0]  length;
        logic [7:0]          message_type;
        logic [15:0]         call_ref;
        crk_t                call_ref_kind;
        status_t             status;
        logic                last_result;
    } rec_t;

    // up to two records per byte, in order
    typedef struct packed {
        logic v0;
        logic v1;
        rec_t r0;
        rec_t r1;
    } rec_pair_t;

    typedef struct packed {
        logic             hit;
        logic             comp;
        logic [POS_W-1:0] pos;
    } lk_t;

    localparam logic [7:0] POS_CODES [IE_POSITIONS] = '{
        8'h04, 8'h08, 8'h10, 8'h14, 8'h18, 8'h1c, 8'h1e, 8'h20,
        8'h27, 8'h28, 8'h29, 8'h2c, 8'h34, 8'h40, 8'h42, 8'h43,
        8'h44, 8'h45, 8'h46, 8'h47, 8'h4a, 8'h4c, 8'h4d, 8'h6c,
        8'h6d, 8'h70, 8'h71, 8'h74, 8'h76, 8'h78, 8'h79, 8'h7c,
        8'h7d, 8'h7e
    };

    // position table lookup; codes are unique so at most one compare hits
    function automatic lk_t pos_lookup(input logic [7:0] ie);
        lk_t r;
        r = '0;
        for (int i = 0; i < IE_POSITIONS; i++)
        begin
            if (POS_CODES[i] == ie)
            begin
                r.hit = 1'b1;
                r.pos = POS_W'(i);
            end
        end
        if (!r.hit && ie != 8'd0 && ie < COMP_LIMIT)
        begin
            r.comp = 1'b1;
        end
        return r;
    endfunction

    function automatic rec_t make_rec(
        input kind_t              k,
        input logic [7:0]         ie,
        input logic [POS_W-1:0]   idx,
        input logic               rep,
        input logic [FIELD_W-1:0] off,
        input logic [FIELD_W-1:0] len
    );
        rec_t r;
        r          = '0;
        r.kind     = k;
        r.ie_code  = ie;
        r.index    = idx;
        r.repeated = rep;
        r.offset   = off;
        r.length   = len;
        return r;
    endfunction

endpackage

// ----- sv/q931_byte_if.sv -----
// byte channel: one message byte per transaction
interface q931_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/q931_rec_if.sv -----
// record channel: one parse record per transaction
interface q931_rec_if;
    import q931_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         ie_code;
    logic [POS_W-1:0]   index;
    logic               repeated;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
    logic [7:0]         message_type;
    logic [15:0]        call_ref;
    logic [1:0]         call_ref_kind;
    logic [2:0]         status;
    logic               last_result;

    modport source (
        output valid, output kind, output ie_code, output index, output repeated,
        output offset, output length, output message_type, output call_ref,
        output call_ref_kind, output status, output last_result,
        input ready
    );
    modport sink (
        input valid, input kind, input ie_code, input index, input repeated,
        input offset, input length, input message_type, input call_ref,
        input call_ref_kind, input status, input last_result,
        output ready
    );
endinterface

// ----- sv/q931_message_parser.sv -----
// top level of the q.931 message parser
//
// The parser takes a q.931 message one byte per transaction on msg_bytes
// (last_byte marks the final byte) and reports on records: one record per
// placed variable element (first occurrences by table position, repeats in
// one of eight extra slots), per recognised single-octet element in codeset
// 0, and per shifted codeset region, then a summary record with message
// type, call reference, reference kind and status that closes the message.
// Every byte is parsed in the cycle it is accepted: a byte can be taken in
// every clock cycle, and a byte yields at most two records. Records leave
// through a four-entry queue, one per transaction; the input stalls only
// while more than two records wait there, so with the record side always
// ready the rate is one byte per cycle while at most two records wait. The
// first record of a byte appears on the output in the cycle after the byte
// at the earliest; the second record of a pair, or a record queued behind
// others, comes later. After a fatal error the rest of the message is
// consumed without records until its summary. No clearing pass after reset.
module q931_message_parser (
    input  logic        clk,
    input  logic        rst_n,
    q931_byte_if.sink   msg_bytes,
    q931_rec_if.source  records
);
    import q931_pkg::*;

    logic      space;
    logic      accept;
    rec_pair_t pair;

    // byte transaction completes when the queue can hold two more records
    assign msg_bytes.ready = space;
    assign accept          = msg_bytes.valid && space;

    // parser state and per-byte logic
    q931_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (msg_bytes.data_byte),
        .last_byte (msg_bytes.last_byte),
        .pair      (pair)
    );

    // record queue decouples the record side from the byte side
    q931_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .pair    (pair),
        .space   (space),
        .records (records)
    );

endmodule

// ----- sv/q931_step.sv -----
// parser state registers and the per-byte next-state and record logic
module q931_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output q931_pkg::rec_pair_t pair
);
    import q931_pkg::*;

    typedef struct packed {
        phase_t              phase;
        logic [OFF_W-1:0]    byte_offset;
        logic [7:0]          remaining_count;
        logic [7:0]          current_element;
        logic [2:0]          active_codeset;
        logic [2:0]          locked_codeset;
        logic                open_region_valid;
        logic [SLOT_W-1:0]   open_region_slot;
        logic [OFF_W-1:0]    open_region_start;
        logic [7:0]          region_octet;
        logic [SLOT_W:0]     extra_slots_used;
        logic [IE_POSITIONS-1:0] seen_positions;
        logic [1:0]          soft_errors;
        status_t             fatal_status;
        logic [1:0]          ref_length;
        logic [15:0]         reference_value;
        logic [7:0]          type_octet;
        logic [7:0]          comprehension_element;
        logic [FIELD_W-1:0]  elem_len_offset;
        logic [7:0]          elem_length;
    } st_t;

    typedef struct packed {
        logic single;
        logic elem_first;
        logic elem_rep;
        logic close_shift;
        logic close_end;
        logic last_region;
        logic summary;
    } ev_t;

    localparam st_t ST_RESET = '0;

    st_t              st_reg;
    st_t              st_next;
    ev_t              ev;
    logic             do_complete;
    logic             do_end;
    lk_t              lk;
    logic [OFF_W-1:0] off;
    logic [7:0]       rem_dec;
    logic [15:0]      ref_shift;
    logic [2:0]       cs;
    logic             slot_full;
    logic             is_single;
    rec_t             cand [4];
    logic [3:0]       cand_v;
    logic [1:0]       n_found;

    function automatic st_t go_fatal(input st_t s, input status_t code);
        st_t r;
        r                   = s;
        r.fatal_status      = code;
        r.phase             = PH_DROP;
        r.open_region_valid = 1'b0;
        return r;
    endfunction

    assign off       = st_reg.byte_offset;
    assign lk        = pos_lookup(st_reg.current_element);
    assign rem_dec   = st_reg.remaining_count - 8'd1;
    assign ref_shift = {st_reg.reference_value[7:0], data_byte};
    assign cs        = data_byte[2:0];
    assign slot_full = st_reg.extra_slots_used >= (SLOT_W + 1)'(EXTRA_SLOTS);
    assign is_single = data_byte == OCT_MORE || data_byte == OCT_COMPLETE
                    || data_byte[7:4] == CONGESTION_HI;

    // next state and record events
    always_comb
    begin
        st_next     = st_reg;
        ev          = '0;
        do_complete = 1'b0;
        do_end      = 1'b0;

        if (st_reg.phase != PH_DROP && off >= OFF_W'(MAX_MSG_BYTES))
        begin
            st_next = go_fatal(st_next, STAT_LENGTH);
        end
        if (off < OFF_W'(MAX_MSG_BYTES))
        begin
            st_next.byte_offset = off + OFF_W'(1);
        end

        unique case (st_next.phase)
            PH_PD:
            begin
                st_next.phase = PH_CRLEN;
            end
            PH_CRLEN:
            begin
                if (data_byte > MAX_REF_LEN)
                begin
                    st_next = go_fatal(st_next, STAT_BAD_REF_LEN);
                end
                else
                begin
                    st_next.ref_length      = data_byte[1:0];
                    st_next.reference_value = '0;
                    st_next.remaining_count = data_byte;
                    st_next.phase = (data_byte == 8'd0) ? PH_TYPE : PH_CREF;
                end
            end
            PH_CREF:
            begin
                st_next.remaining_count = rem_dec;
                st_next.reference_value = ref_shift;
                if (rem_dec == 8'd0)
                begin
                    if (st_reg.ref_length == 2'd1 && ref_shift[7])
                    begin
                        st_next.reference_value = (ref_shift | REF_FLAG) & REF_FLAG_MASK;
                    end
                    st_next.phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                st_next.type_octet = data_byte;
                st_next.phase      = PH_IE;
            end
            PH_IE:
            begin
                st_next.current_element = data_byte;
                if (data_byte[7:4] == SHIFT_HI)
                begin
                    st_next.active_codeset = cs;
                    if (!data_byte[3])
                    begin
                        st_next.locked_codeset = cs;
                    end
                    if (st_reg.open_region_valid)
                    begin
                        ev.close_shift            = 1'b1;
                        st_next.open_region_valid = 1'b0;
                    end
                    if (cs != 3'd0)
                    begin
                        if (slot_full)
                        begin
                            st_next = go_fatal(st_next, STAT_SLOT_OVERFLOW);
                        end
                        else
                        begin
                            st_next.open_region_valid = 1'b1;
                            st_next.open_region_slot  = st_reg.extra_slots_used[SLOT_W-1:0];
                            st_next.open_region_start = off + OFF_W'(1);
                            st_next.region_octet      = data_byte;
                            st_next.extra_slots_used  =
                                st_reg.extra_slots_used + (SLOT_W + 1)'(1);
                        end
                    end
                end
                else if (data_byte[7])
                begin
                    if (st_reg.active_codeset == 3'd0)
                    begin
                        if (is_single)
                        begin
                            ev.single = 1'b1;
                        end
                        else
                        begin
                            st_next.soft_errors = st_next.soft_errors | 2'b01;
                        end
                    end
                    do_end = 1'b1;
                end
                else
                begin
                    st_next.phase = PH_IELEN;
                end
            end
            PH_IELEN:
            begin
                st_next.elem_len_offset = FIELD_W'(off);
                st_next.elem_length     = data_byte;
                st_next.remaining_count = data_byte;
                if (data_byte == 8'd0)
                begin
                    do_complete = 1'b1;
                end
                else
                begin
                    st_next.phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                st_next.remaining_count = rem_dec;
                if (rem_dec == 8'd0)
                begin
                    do_complete = 1'b1;
                end
            end
            PH_DROP:
            begin
            end
        endcase

        // variable element complete: place it through the position table
        if (do_complete)
        begin
            do_end = 1'b1;
            if (st_reg.active_codeset == 3'd0)
            begin
                if (lk.hit)
                begin
                    if (!st_reg.seen_positions[lk.pos])
                    begin
                        st_next.seen_positions[lk.pos] = 1'b1;
                        ev.elem_first = 1'b1;
                    end
                    else if (slot_full)
                    begin
                        st_next = go_fatal(st_next, STAT_SLOT_OVERFLOW);
                        do_end  = 1'b0;
                    end
                    else
                    begin
                        ev.elem_rep = 1'b1;
                        st_next.extra_slots_used =
                            st_reg.extra_slots_used + (SLOT_W + 1)'(1);
                    end
                end
                else if (lk.comp)
                begin
                    st_next.soft_errors           = st_next.soft_errors | 2'b11;
                    st_next.comprehension_element = st_reg.current_element;
                end
                else
                begin
                    st_next.soft_errors = st_next.soft_errors | 2'b01;
                end
            end
        end

        // end of element: non-locking region closes, codeset falls back
        if (do_end)
        begin
            if (st_reg.active_codeset != 3'd0
                && st_reg.active_codeset != st_reg.locked_codeset
                && st_reg.open_region_valid)
            begin
                ev.close_end              = 1'b1;
                st_next.open_region_valid = 1'b0;
            end
            st_next.active_codeset = st_reg.locked_codeset;
            st_next.phase          = PH_IE;
        end

        if (last_byte)
        begin
            if (st_next.phase != PH_DROP && st_next.phase != PH_IE)
            begin
                st_next = go_fatal(st_next, STAT_LENGTH);
            end
            if (st_next.phase == PH_IE && st_next.open_region_valid
                && st_next.open_region_start <= off)
            begin
                ev.last_region = 1'b1;
            end
            ev.summary = 1'b1;
        end
    end

    // candidate records in emission order, then the first two are taken
    always_comb
    begin
        cand[0] = '0;
        cand[1] = '0;
        cand[2] = '0;
        cand[3] = '0;
        pair    = '0;
        n_found = '0;

        priority if (ev.single)
        begin
            cand[0] = make_rec(KIND_SINGLE, data_byte, '0, 1'b0, FIELD_W'(off), '0);
        end
        else if (ev.elem_first)
        begin
            cand[0] = make_rec(KIND_VAR, st_reg.current_element, lk.pos, 1'b0,
                               st_next.elem_len_offset, FIELD_W'(st_next.elem_length));
        end
        else if (ev.elem_rep)
        begin
            cand[0] = make_rec(KIND_VAR, st_reg.current_element,
                               POS_W'(st_reg.extra_slots_used), 1'b1,
                               st_next.elem_len_offset, FIELD_W'(st_next.elem_length));
        end

        priority if (ev.close_shift)
        begin
            cand[1] = make_rec(KIND_REGION, st_reg.region_octet,
                               POS_W'(st_reg.open_region_slot), 1'b0,
                               FIELD_W'(st_reg.open_region_start),
                               FIELD_W'(off - st_reg.open_region_start));
        end
        else if (ev.close_end)
        begin
            cand[1] = make_rec(KIND_REGION, st_reg.region_octet,
                               POS_W'(st_reg.open_region_slot), 1'b0,
                               FIELD_W'(st_reg.open_region_start),
                               FIELD_W'(off + OFF_W'(1) - st_reg.open_region_start));
        end

        cand[2] = make_rec(KIND_REGION, st_next.region_octet,
                           POS_W'(st_next.open_region_slot), 1'b0,
                           FIELD_W'(st_next.open_region_start),
                           FIELD_W'(off + OFF_W'(1) - st_next.open_region_start));

        cand[3] = make_rec(KIND_SUMMARY, st_next.comprehension_element, '0, 1'b0, '0, '0);
        cand[3].message_type = st_next.type_octet;
        cand[3].call_ref     = st_next.reference_value;
        cand[3].last_result  = 1'b1;
        priority if (st_next.ref_length == 2'd0)
        begin
            cand[3].call_ref_kind = CRK_DUMMY;
        end
        else if (st_next.reference_value[14:0] == 15'd0)
        begin
            cand[3].call_ref_kind = CRK_GLOBAL;
        end
        else
        begin
            cand[3].call_ref_kind = CRK_ORDINARY;
        end
        priority if (st_next.fatal_status != STAT_OK)
        begin
            cand[3].status = st_next.fatal_status;
        end
        else if (st_next.soft_errors[1])
        begin
            cand[3].status = STAT_UNKNOWN_COMP;
        end
        else if (st_next.soft_errors[0])
        begin
            cand[3].status = STAT_UNKNOWN_IE;
        end
        else
        begin
            cand[3].status = STAT_OK;
        end

        cand_v = {ev.summary, ev.last_region, ev.close_shift | ev.close_end,
                  ev.single | ev.elem_first | ev.elem_rep};

        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i])
            begin
                if (n_found == 2'd0)
                begin
                    pair.v0 = 1'b1;
                    pair.r0 = cand[i];
                end
                else
                begin
                    pair.v1 = 1'b1;
                    pair.r1 = cand[i];
                end
                n_found = n_found + 2'd1;
            end
        end
    end

    // state returns to reset after the summary of each message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else if (accept)
        begin
            st_reg <= last_byte ? ST_RESET : st_next;
        end
    end

endmodule

// ----- sv/q931_outq.sv -----
// record queue: takes up to two records per cycle, delivers one per transaction
module q931_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  q931_pkg::rec_pair_t pair,
    output logic                space,
    q931_rec_if.source          records
);
    import q931_pkg::*;

    rec_t             q_reg  [QUEUE_DEPTH];
    rec_t             q_next [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] n_push;
    logic             pop;

    assign records.valid = count_reg != '0;
    assign pop           = records.valid && records.ready;
    assign space         = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign base          = count_reg - CNT_W'(pop);
    assign n_push        = push ? (CNT_W'(pair.v0) + CNT_W'(pair.v1)) : '0;
    assign count_next    = base + n_push;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (push && pair.v0 && base == CNT_W'(i))
            begin
                q_next[i] = pair.r0;
            end
            if (push && pair.v1 && base + CNT_W'(1) == CNT_W'(i))
            begin
                q_next[i] = pair.r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign records.kind          = q_reg[0].kind;
    assign records.ie_code       = q_reg[0].ie_code;
    assign records.index         = q_reg[0].index;
    assign records.repeated      = q_reg[0].repeated;
    assign records.offset        = q_reg[0].offset;
    assign records.length        = q_reg[0].length;
    assign records.message_type  = q_reg[0].message_type;
    assign records.call_ref      = q_reg[0].call_ref;
    assign records.call_ref_kind = q_reg[0].call_ref_kind;
    assign records.status        = q_reg[0].status;
    assign records.last_result   = q_reg[0].last_result;

endmodule

// ----- tb/q931_parse_checker.sv -----
// record checker of the q.931 message parser: byte-level parse prediction and record compare
`timescale 1ns / 100ps

module q931_parse_checker (
    input  logic  clk,
    input  logic  rst_n,
    q931_byte_if  msg_bytes,
    q931_rec_if   records,
    output int    pending,
    output int    fail_count
);
    import q931_pkg::*;

    localparam int NOT_FOUND     = -1;
    localparam int COMP_REQUIRED = -2;

    localparam logic [7:0] IE_TABLE [34] = '{
        8'h04, 8'h08, 8'h10, 8'h14, 8'h18, 8'h1c, 8'h1e, 8'h20,
        8'h27, 8'h28, 8'h29, 8'h2c, 8'h34, 8'h40, 8'h42, 8'h43,
        8'h44, 8'h45, 8'h46, 8'h47, 8'h4a, 8'h4c, 8'h4d, 8'h6c,
        8'h6d, 8'h70, 8'h71, 8'h74, 8'h76, 8'h78, 8'h79, 8'h7c,
        8'h7d, 8'h7e
    };

    // parse state of the message in flight
    phase_t      ph;
    logic [10:0] byte_pos;
    logic [7:0]  left_cnt;
    logic [7:0]  cur_ie;
    logic [2:0]  active_cs;
    logic [2:0]  locked_cs;
    logic        region_open;
    logic [2:0]  region_slot;
    logic [10:0] region_start;
    logic [7:0]  region_ie;
    logic [3:0]  slots_used;
    logic [33:0] seen;
    logic [1:0]  soft_err;
    status_t     fatal_code;
    logic [1:0]  cref_len;
    logic [15:0] cref;
    logic [7:0]  msg_type;
    logic [7:0]  comp_ie;
    logic [10:0] len_pos;
    logic [7:0]  ie_len;

    rec_t expected_recs[$];

    function automatic void clear_message();
        ph           = PH_PD;
        byte_pos     = '0;
        left_cnt     = '0;
        cur_ie       = '0;
        active_cs    = '0;
        locked_cs    = '0;
        region_open  = 1'b0;
        region_slot  = '0;
        region_start = '0;
        region_ie    = '0;
        slots_used   = '0;
        seen         = '0;
        soft_err     = '0;
        fatal_code   = STAT_OK;
        cref_len     = '0;
        cref         = '0;
        msg_type     = '0;
        comp_ie      = '0;
        len_pos      = '0;
        ie_len       = '0;
    endfunction

    function automatic void add_rec(input kind_t k, input logic [7:0] ie,
                                    input logic [5:0] idx, input logic rep,
                                    input logic [10:0] off, input logic [10:0] len);
        rec_t r;
        r          = '0;
        r.kind     = k;
        r.ie_code  = ie;
        r.index    = idx;
        r.repeated = rep;
        r.offset   = off[9:0];
        r.length   = len[9:0];
        expected_recs.push_back(r);
    endfunction

    function automatic void abort(input status_t code);
        fatal_code  = code;
        ph          = PH_DROP;
        region_open = 1'b0;
    endfunction

    function automatic int ie_position(input logic [7:0] ie);
        for (int i = 0; i < 34; i++)
        begin
            if (IE_TABLE[i] == ie)
            begin
                return i;
            end
        end
        if (ie != 8'h00 && ie < COMP_LIMIT)
        begin
            return COMP_REQUIRED;
        end
        return NOT_FOUND;
    endfunction

    // end of any element: a non-locking region ends here
    function automatic void finish_elem(input logic [10:0] off);
        if (active_cs != 3'd0 && active_cs != locked_cs && region_open)
        begin
            add_rec(KIND_REGION, region_ie, 6'(region_slot), 1'b0, region_start,
                    off + 11'd1 - region_start);
            region_open = 1'b0;
        end
        active_cs = locked_cs;
        ph        = PH_IE;
    endfunction

    function automatic void place_elem(input logic [10:0] off);
        int p;
        if (active_cs == 3'd0)
        begin
            p = ie_position(cur_ie);
            if (p >= 0)
            begin
                if (!seen[p])
                begin
                    seen[p] = 1'b1;
                    add_rec(KIND_VAR, cur_ie, 6'(p), 1'b0, len_pos, 11'(ie_len));
                end
                else if (slots_used >= EXTRA_SLOTS)
                begin
                    abort(STAT_SLOT_OVERFLOW);
                    return;
                end
                else
                begin
                    add_rec(KIND_VAR, cur_ie, 6'(slots_used), 1'b1, len_pos, 11'(ie_len));
                    slots_used++;
                end
            end
            else if (p == COMP_REQUIRED)
            begin
                soft_err = 2'b11;
                comp_ie  = cur_ie;
            end
            else
            begin
                soft_err[0] = 1'b1;
            end
        end
        finish_elem(off);
    endfunction

    function automatic void take_shift(input logic [7:0] b, input logic [10:0] off);
        active_cs = b[2:0];
        if (!b[3])
        begin
            locked_cs = b[2:0];
        end
        if (region_open)
        begin
            add_rec(KIND_REGION, region_ie, 6'(region_slot), 1'b0, region_start,
                    off - region_start);
            region_open = 1'b0;
        end
        if (b[2:0] != 3'd0)
        begin
            if (slots_used >= EXTRA_SLOTS)
            begin
                abort(STAT_SLOT_OVERFLOW);
                return;
            end
            region_open  = 1'b1;
            region_slot  = slots_used[2:0];
            region_start = off + 11'd1;
            region_ie    = b;
            slots_used++;
        end
    endfunction

    function automatic void take_ie(input logic [7:0] b, input logic [10:0] off);
        cur_ie = b;
        if (b[7:4] == SHIFT_HI)
        begin
            take_shift(b, off);
        end
        else if (b[7])
        begin
            if (active_cs == 3'd0)
            begin
                if (b == OCT_MORE || b == OCT_COMPLETE || b[7:4] == CONGESTION_HI)
                begin
                    add_rec(KIND_SINGLE, b, 6'd0, 1'b0, off, 11'd0);
                end
                else
                begin
                    soft_err[0] = 1'b1;
                end
            end
            finish_elem(off);
        end
        else
        begin
            ph = PH_IELEN;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        logic [10:0] off;
        rec_t        s;
        off = byte_pos;
        if (ph != PH_DROP && off >= MAX_MSG_BYTES)
        begin
            abort(STAT_LENGTH);
        end
        if (byte_pos < MAX_MSG_BYTES)
        begin
            byte_pos++;
        end
        case (ph)
            PH_PD:
            begin
                ph = PH_CRLEN;
            end
            PH_CRLEN:
            begin
                if (b > MAX_REF_LEN)
                begin
                    abort(STAT_BAD_REF_LEN);
                end
                else
                begin
                    cref_len = b[1:0];
                    cref     = '0;
                    left_cnt = b;
                    ph       = (b == 8'd0) ? PH_TYPE : PH_CREF;
                end
            end
            PH_CREF:
            begin
                cref = {cref[7:0], b};
                left_cnt--;
                if (left_cnt == 8'd0)
                begin
                    // one-byte reference carries its flag in bit 7
                    if (cref_len == 2'd1 && cref[7])
                    begin
                        cref = (cref | REF_FLAG) & REF_FLAG_MASK;
                    end
                    ph = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                msg_type = b;
                ph       = PH_IE;
            end
            PH_IE:
            begin
                take_ie(b, off);
            end
            PH_IELEN:
            begin
                len_pos  = off;
                ie_len   = b;
                left_cnt = b;
                if (b == 8'd0)
                begin
                    place_elem(off);
                end
                else
                begin
                    ph = PH_BODY;
                end
            end
            PH_BODY:
            begin
                left_cnt--;
                if (left_cnt == 8'd0)
                begin
                    place_elem(off);
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            if (ph != PH_DROP && ph != PH_IE)
            begin
                abort(STAT_LENGTH);
            end
            // a shift on the final byte leaves an empty region with no record
            if (ph == PH_IE && region_open && region_start <= off)
            begin
                add_rec(KIND_REGION, region_ie, 6'(region_slot), 1'b0, region_start,
                        off + 11'd1 - region_start);
            end
            s              = '0;
            s.kind         = KIND_SUMMARY;
            s.ie_code      = comp_ie;
            s.message_type = msg_type;
            s.call_ref     = cref;
            s.last_result  = 1'b1;
            if (fatal_code != STAT_OK)
            begin
                s.status = fatal_code;
            end
            else if (soft_err[1])
            begin
                s.status = STAT_UNKNOWN_COMP;
            end
            else if (soft_err[0])
            begin
                s.status = STAT_UNKNOWN_IE;
            end
            else
            begin
                s.status = STAT_OK;
            end
            if (cref_len == 2'd0)
            begin
                s.call_ref_kind = CRK_DUMMY;
            end
            else if (cref[14:0] == 15'd0)
            begin
                s.call_ref_kind = CRK_GLOBAL;
            end
            else
            begin
                s.call_ref_kind = CRK_ORDINARY;
            end
            expected_recs.push_back(s);
            clear_message();
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rec_t want;
        if (!rst_n)
        begin
            clear_message();
            expected_recs.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            // records leave in the cycle after their byte or later; compare, then predict
            if (records.valid && records.ready)
            begin
                if (expected_recs.size() == 0)
                begin
                    $error("record kind %0d with no record expected", records.kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_recs.pop_front();
                    check_field("kind", 16'(want.kind), 16'(records.kind));
                    check_field("ie_code", 16'(want.ie_code), 16'(records.ie_code));
                    check_field("index", 16'(want.index), 16'(records.index));
                    check_field("repeated", 16'(want.repeated), 16'(records.repeated));
                    check_field("offset", 16'(want.offset), 16'(records.offset));
                    check_field("length", 16'(want.length), 16'(records.length));
                    check_field("message_type", 16'(want.message_type),
                                16'(records.message_type));
                    check_field("call_ref", want.call_ref, records.call_ref);
                    check_field("call_ref_kind", 16'(want.call_ref_kind),
                                16'(records.call_ref_kind));
                    check_field("status", 16'(want.status), 16'(records.status));
                    check_field("last_result", 16'(want.last_result),
                                16'(records.last_result));
                end
            end
            if (msg_bytes.valid && msg_bytes.ready)
            begin
                parse_byte(msg_bytes.data_byte, msg_bytes.last_byte);
            end
            pending <= expected_recs.size();
        end
    end

endmodule

// ----- tb/tb_q931_message_parser.sv -----
// testbench top of the q.931 message parser: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_q931_message_parser;
    import q931_pkg::*;

    // number of bytes after which no new message is started
    localparam int ITEMS      = 1950;
    // cycles with no transaction on either channel before the run is given up;
    // the one long receiver hold-off is set by HOLD_LEN, every other stall is short
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req = 1'b0;

    int pending;
    int fail_count;

    // sender state: bytes left in the current burst
    int burst_left;
    int bytes_sent;

    // message under construction and the index that carries last_byte
    logic [7:0] msg_q[$];
    int         last_idx;

    q931_byte_if msg_if ();
    q931_rec_if  rec_if ();

    always #2 clk = ~clk;

    q931_message_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_bytes (msg_if),
        .records   (rec_if)
    );

    // watches both channels, predicts the records and counts mismatches
    q931_parse_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_bytes  (msg_if),
        .records    (rec_if),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // offer one byte and hold it until a transaction takes it; bursts of
    // random length are separated by random gaps, some of them zero
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                msg_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= b;
        msg_if.last_byte <= fin;
        @(posedge clk);
        while (msg_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i <= last_idx; i++)
        begin
            send_byte(msg_q[i], i == last_idx);
        end
    endtask

    // stop offering and wait until every predicted record has come out
    task automatic drain_expected();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // random message: mostly a sound header followed by a mix of variable
    // elements (table codes, a small pool that repeats often, unknown and
    // comprehension-required codes), single-octet elements and shifts;
    // some messages are cut short, and the long one ends near or past the size limit
    function automatic void make_message(input bit long_one);
        int         crlen;
        int         n_elem;
        int         n_done;
        int         target;
        int         sel;
        int         len;
        logic [7:0] code;
        msg_q.delete();
        n_done = 0;
        target = $urandom_range(1018, 1032);
        msg_q.push_back(8'($urandom_range(0, 255)));

        // call reference length: 0..2 mostly, an illegal length now and then
        sel = $urandom_range(0, 19);
        if (long_one || (sel >= 12 && sel < 18))
        begin
            crlen = 2;
        end
        else if (sel < 6)
        begin
            crlen = 0;
        end
        else if (sel < 12)
        begin
            crlen = 1;
        end
        else
        begin
            crlen = $urandom_range(3, 255);
        end
        msg_q.push_back(8'(crlen));
        if (crlen <= 2)
        begin
            for (int i = 0; i < crlen; i++)
            begin
                // zero bytes make global references likely
                msg_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 :
                                8'($urandom_range(0, 255)));
            end
        end
        msg_q.push_back(8'($urandom_range(0, 255)));

        // a few crowded messages run the extra slots out
        n_elem = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 7);
        while (long_one ? (msg_q.size() < target) : (n_done < n_elem))
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                case ($urandom_range(0, 13))
                    0, 1, 2, 3, 4, 5, 6, 7: code = POS_CODES[$urandom_range(0, 33)];
                    8, 9, 10:               code = POS_CODES[$urandom_range(0, 3)];
                    11:                     code = 8'($urandom_range(1, 15));
                    12:                     code = 8'h00;
                    default:                code = 8'($urandom_range(0, 127));
                endcase
                if (long_one || $urandom_range(0, 31) == 0)
                begin
                    len = $urandom_range(0, 255);
                end
                else
                begin
                    len = $urandom_range(0, 6);
                end
                msg_q.push_back(code);
                msg_q.push_back(8'(len));
                for (int i = 0; i < len; i++)
                begin
                    msg_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            else if (sel < 8)
            begin
                case ($urandom_range(0, 3))
                    0:       code = OCT_MORE;
                    1:       code = OCT_COMPLETE;
                    2:       code = {CONGESTION_HI, 4'($urandom_range(0, 15))};
                    default: code = 8'($urandom_range(128, 255));
                endcase
                msg_q.push_back(code);
            end
            else
            begin
                // locking when bit 3 is clear, codeset in the low three bits
                msg_q.push_back({SHIFT_HI, 4'($urandom_range(0, 15))});
            end
            n_done++;
        end

        if (long_one)
        begin
            last_idx = target - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            // early end anywhere, the header included
            last_idx = $urandom_range(0, msg_q.size() - 1);
        end
        else
        begin
            last_idx = msg_q.size() - 1;
        end
    endfunction

    // receiver: ready follows a pattern chosen anew for each segment of random
    // length (always ready, coin flip, mostly stalled, periodic stall); once asked,
    // it holds off for a long stretch so the output queue fills up and the
    // byte side stalls while the sender keeps offering
    initial
    begin
        int seg_left;
        int mode;
        int hold_left;
        bit hold_done;
        rec_if.ready = 1'b0;
        seg_left     = 0;
        mode         = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(32, 256);
                mode     = $urandom_range(0, 3);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rec_if.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rec_if.ready <= 1'b1;
                    1:       rec_if.ready <= 1'($urandom_range(0, 1));
                    2:       rec_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rec_if.ready <= (seg_left % 3 != 0);
                endcase
            end
        end
    end

    // watchdog: too long without any transaction ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((msg_if.valid && msg_if.ready) || (rec_if.valid && rec_if.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        bit long_done;
        rst_n            = 1'b0;
        msg_if.valid     = 1'b0;
        msg_if.data_byte = 8'h00;
        msg_if.last_byte = 1'b0;
        burst_left       = 0;
        bytes_sent       = 0;
        long_done        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // one-byte reference with its flag set, a placed element, sending
        // complete, congestion, a locking shift whose region the next shift closes,
        // then a locking shift whose region ends with the message
        msg_q    = '{8'h08, 8'h01, 8'h85, 8'h05, 8'h04, 8'h01, 8'h00, 8'ha1,
                     8'hb3, 8'h96, 8'h70, 8'h00, 8'h95, 8'hff};
        last_idx = msg_q.size() - 1;
        send_message();

        // call reference length beyond two
        msg_q    = '{8'h08, 8'h03, 8'hff};
        last_idx = msg_q.size() - 1;
        send_message();

        // global reference, a comprehension-required unknown element, an
        // unknown single-octet element and a shift on the final byte
        msg_q    = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h7b, 8'h01, 8'h00, 8'ha2, 8'h9d};
        last_idx = msg_q.size() - 1;
        send_message();

        // sender pause until every record is back, then the long hold-off
        // starts while the random traffic keeps coming
        drain_expected();
        hold_req <= 1'b1;

        while (bytes_sent < ITEMS)
        begin
            if (!long_done && bytes_sent >= 300)
            begin
                long_done = 1'b1;
                make_message(1'b1);
            end
            else
            begin
                make_message(1'b0);
            end
            send_message();
        end

        drain_expected();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
